FILE: rtl/pbu_pkg.sv
// Shared types, codes and sizes for the pixel blend unit.
package pbu_pkg;

   localparam int NUM_CH      = 3;
   localparam int MODE_W      = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [QPTR_W-1:0] ptr_type;
   typedef logic [QCNT_W-1:0] cnt_type;

   localparam mode_type MODE_NONE  = 3'd0;
   localparam mode_type MODE_ALPHA = 3'd1;
   localparam mode_type MODE_ADD   = 3'd2;
   localparam mode_type MODE_SUB   = 3'd3;
   localparam mode_type MODE_MUL   = 3'd4;

   typedef enum logic [2:0] {
      OP_PASS,
      OP_COPY,
      OP_ALPHA,
      OP_ADD,
      OP_SUB,
      OP_MUL
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [7:0]              alpha;
      logic [7:0]              weight;
      logic [NUM_CH-1:0][7:0]  src;
      logic [NUM_CH-1:0][7:0]  dst;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      op_type                  op;
      logic [7:0]              alpha;
      logic [NUM_CH-1:0][15:0] sa_prod;
      logic [NUM_CH-1:0][15:0] nd_prod;
      logic [NUM_CH-1:0][7:0]  src;
      logic [NUM_CH-1:0][7:0]  dst;
   } s1_type;

   typedef struct packed {
      op_type                  op;
      logic [7:0]              alpha;
      logic [NUM_CH-1:0][23:0] triple;
      logic [NUM_CH-1:0][7:0]  nd_hi;
      logic [NUM_CH-1:0][7:0]  simple;
   } s2_type;

endpackage

FILE: rtl/pbu_front.sv
// Front end: mode register, input acceptance and per-pixel operation classification.
module pbu_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_blend_mode,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_src_alpha,
   input  logic [7:0]             req_src_red,
   input  logic [7:0]             req_src_green,
   input  logic [7:0]             req_src_blue,
   input  logic [7:0]             req_dst_alpha_in,
   input  logic [7:0]             req_dst_red_in,
   input  logic [7:0]             req_dst_green_in,
   input  logic [7:0]             req_dst_blue_in,
   input  pbu_pkg::q_status_type  q_status,
   output logic                   q_push,
   output pbu_pkg::item_type      q_push_data
);

   pbu_pkg::mode_type mode_ff;
   pbu_pkg::mode_type mode_in;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (csr_valid && csr_ready) begin
         mode_in = csr_blend_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pbu_pkg::MODE_NONE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !req_stall;

   // Classify the pixel; a transparent source in replace mode becomes a pass.
   always_comb begin
      q_push_data.weight = req_src_alpha;
      q_push_data.src    = {req_src_blue, req_src_green, req_src_red};
      q_push_data.dst    = {req_dst_blue_in, req_dst_green_in, req_dst_red_in};
      q_push_data.alpha  = req_dst_alpha_in;
      case (mode_ff)
         pbu_pkg::MODE_NONE: begin
            if (req_src_alpha != 8'd0) begin
               q_push_data.op    = pbu_pkg::OP_COPY;
               q_push_data.alpha = req_src_alpha;
            end else begin
               q_push_data.op = pbu_pkg::OP_PASS;
            end
         end
         pbu_pkg::MODE_ALPHA: q_push_data.op = pbu_pkg::OP_ALPHA;
         pbu_pkg::MODE_ADD:   q_push_data.op = pbu_pkg::OP_ADD;
         pbu_pkg::MODE_SUB:   q_push_data.op = pbu_pkg::OP_SUB;
         pbu_pkg::MODE_MUL:   q_push_data.op = pbu_pkg::OP_MUL;
         default:             q_push_data.op = pbu_pkg::OP_PASS;
      endcase
   end

endmodule

FILE: rtl/pbu_queue.sv
// Small FIFO that decouples the front end from the arithmetic back end.
module pbu_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pbu_pkg::item_type      push_data,
   input  logic                   pop,
   output pbu_pkg::item_type      pop_data,
   output pbu_pkg::q_status_type  status
);

   pbu_pkg::item_type entries_ff [pbu_pkg::QUEUE_DEPTH];
   pbu_pkg::ptr_type  wr_ptr_ff;
   pbu_pkg::ptr_type  wr_ptr_in;
   pbu_pkg::ptr_type  rd_ptr_ff;
   pbu_pkg::ptr_type  rd_ptr_in;
   pbu_pkg::cnt_type  count_ff;
   pbu_pkg::cnt_type  count_in;

   assign status.full  = (count_ff == pbu_pkg::cnt_type'(pbu_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/pbu_back.sv
// Back end: three-stage blend datapath ending in the result register.
module pbu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  pbu_pkg::q_status_type  q_status,
   input  pbu_pkg::item_type      q_pop_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_alpha,
   output logic [7:0]             rsp_out_red,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_blue
);

   logic                          advance;
   logic                          s1_valid_ff;
   logic                          s2_valid_ff;
   logic                          s3_valid_ff;
   pbu_pkg::s1_type               s1_ff;
   pbu_pkg::s1_type               s1_in;
   pbu_pkg::s2_type               s2_ff;
   pbu_pkg::s2_type               s2_in;
   logic [7:0]                    s3_alpha_ff;
   logic [pbu_pkg::NUM_CH-1:0][7:0] s3_chan_ff;
   logic [pbu_pkg::NUM_CH-1:0][7:0] s3_chan_in;

   // Hold every stage while a result waits on the consumer.
   assign advance = !(s3_valid_ff && rsp_stall);
   assign q_pop   = advance && !q_status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= !q_status.empty;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1: source and inverse-alpha products per channel.
   always_comb begin
      s1_in.op    = q_pop_data.op;
      s1_in.alpha = q_pop_data.alpha;
      s1_in.src   = q_pop_data.src;
      s1_in.dst   = q_pop_data.dst;
      for (int i = 0; i < pbu_pkg::NUM_CH; i++) begin
         s1_in.sa_prod[i] = q_pop_data.src[i] * q_pop_data.weight;
         s1_in.nd_prod[i] = (8'd255 - q_pop_data.weight) * q_pop_data.dst[i];
      end
   end

   // Stage 2: finish the single-product modes, start the triple product.
   always_comb begin
      logic [16:0] wsum;
      logic [8:0]  asum;
      logic [7:0]  k;
      s2_in.op    = s1_ff.op;
      s2_in.alpha = s1_ff.alpha;
      for (int i = 0; i < pbu_pkg::NUM_CH; i++) begin
         wsum = {1'b0, s1_ff.sa_prod[i]} + {1'b0, s1_ff.nd_prod[i]};
         k    = s1_ff.sa_prod[i][15:8];
         asum = {1'b0, s1_ff.dst[i]} + {1'b0, k};
         s2_in.triple[i] = s1_ff.sa_prod[i] * s1_ff.dst[i];
         s2_in.nd_hi[i]  = s1_ff.nd_prod[i][15:8];
         case (s1_ff.op)
            pbu_pkg::OP_COPY:  s2_in.simple[i] = s1_ff.src[i];
            pbu_pkg::OP_ALPHA: s2_in.simple[i] = wsum[15:8];
            pbu_pkg::OP_ADD:   s2_in.simple[i] = asum[8] ? 8'd255 : asum[7:0];
            pbu_pkg::OP_SUB:   s2_in.simple[i] = (k > s1_ff.dst[i]) ? 8'd0
                                                                   : s1_ff.dst[i] - k;
            default:           s2_in.simple[i] = s1_ff.dst[i];
         endcase
      end
   end

   // Stage 3: sum the two multiply terms (low byte) or pass through.
   always_comb begin
      for (int i = 0; i < pbu_pkg::NUM_CH; i++) begin
         if (s2_ff.op == pbu_pkg::OP_MUL) begin
            s3_chan_in[i] = s2_ff.triple[i][23:16] + s2_ff.nd_hi[i];
         end else begin
            s3_chan_in[i] = s2_ff.simple[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         s3_alpha_ff <= s2_ff.alpha;
         s3_chan_ff  <= s3_chan_in;
      end
   end

   assign rsp_valid     = s3_valid_ff;
   assign rsp_out_alpha = s3_alpha_ff;
   assign rsp_out_red   = s3_chan_ff[0];
   assign rsp_out_green = s3_chan_ff[1];
   assign rsp_out_blue  = s3_chan_ff[2];

endmodule

FILE: rtl/pixel_blend_unit.sv
// Top level of the pixel blend unit: front end, decoupling queue and blend back end.
//
// Blends one source ARGB8888 pixel into one destination pixel per clock. The mode
// register (written through the csr_ port, always ready) selects replace, alpha,
// add, subtract or multiply; write it only while no pixel is in flight. A pixel
// accepted on req_ passes in turn through the queue write, the product stage, the
// triple-product stage and the result register before it shows on rsp_. The
// multiply mode's 16x8 product after the 8x8 products sets that depth. While rsp_
// does not stall, sustained rate is one pixel per clock; a four-entry queue
// between the front end and the datapath absorbs short output stalls, and
// req_stall rises only when that queue is full.
module pixel_blend_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_blend_mode,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_src_alpha,
   input  logic [7:0]  req_src_red,
   input  logic [7:0]  req_src_green,
   input  logic [7:0]  req_src_blue,
   input  logic [7:0]  req_dst_alpha_in,
   input  logic [7:0]  req_dst_red_in,
   input  logic [7:0]  req_dst_green_in,
   input  logic [7:0]  req_dst_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_alpha,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue
);

   pbu_pkg::q_status_type q_status;
   pbu_pkg::item_type     q_push_data;
   pbu_pkg::item_type     q_pop_data;
   logic                  q_push;
   logic                  q_pop;

   // Accept and classify each pixel against the current mode.
   pbu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_blend_mode   (csr_blend_mode),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_src_alpha    (req_src_alpha),
      .req_src_red      (req_src_red),
      .req_src_green    (req_src_green),
      .req_src_blue     (req_src_blue),
      .req_dst_alpha_in (req_dst_alpha_in),
      .req_dst_red_in   (req_dst_red_in),
      .req_dst_green_in (req_dst_green_in),
      .req_dst_blue_in  (req_dst_blue_in),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_push_data      (q_push_data)
   );

   // Buffer classified pixels so each side can stall on its own.
   pbu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Run the arithmetic and hold the result until the consumer takes it.
   pbu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_pop_data    (q_pop_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue)
   );

endmodule

FILE: rtl/pbu_checker.sv
// Port-level checker for the pixel blend unit and its bind.
module pbu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_alpha,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_green,
   input logic [7:0] rsp_out_blue
);

   logic [3:0] pending_ff;
   logic [3:0] pending_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_alpha)
         && $stable(rsp_out_red) && $stable(rsp_out_green) && $stable(rsp_out_blue))
      else $error("stalled result dropped or changed");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("result without an outstanding pixel");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'd7)
      else $error("more pixels in flight than queue and pipeline hold");

endmodule

bind pixel_blend_unit pbu_checker u_pbu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_alpha (rsp_out_alpha),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue)
);

FILE: bench/tb_top.sv
// Self-checking bench for the pixel blend unit: queued stimulus, clocked driver and checker.
`timescale 1ns / 1ps

module tb_top;

   // Mode codes with no operation behind them; the block must pass the destination through.
   localparam pbu_pkg::mode_type MODE_SPARE_5 = 3'd5;
   localparam pbu_pkg::mode_type MODE_SPARE_7 = 3'd7;

   localparam int unsigned CH_MAX   = 255;
   localparam int SETTLE_CYCLES     = 6;       // quiet cycles before a mode write
   localparam int DRAIN_CYCLES      = 16;      // extra cycles after the last result
   localparam int REPORT_LIMIT      = 10;
   localparam int RANDOM_PER_PHASE  = 300;
   localparam int MODE_EVERY        = 50;      // pixels between random mode writes
   localparam int TIMEOUT_NS        = 5_000_000;

   // One transfer on the req_ channel: source pixel, then destination pixel (MSB first).
   typedef struct packed {
      logic [7:0] sa, sr, sg, sb;
      logic [7:0] da, dr, dg, db;
   } pixel_pair_type;

   typedef struct packed {
      logic [7:0] alpha, red, green, blue;
   } blend_out_type;

   typedef enum logic [1:0] {JOB_PIXEL, JOB_MODE, JOB_PACE} job_kind_type;

   typedef struct {
      job_kind_type      kind;
      pixel_pair_type    pix;
      pbu_pkg::mode_type mode;
      int                gap_pct;
      int                stall_pct;
   } job_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       csr_valid        = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_blend_mode   = '0;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_src_alpha    = '0;
   logic [7:0] req_src_red      = '0;
   logic [7:0] req_src_green    = '0;
   logic [7:0] req_src_blue     = '0;
   logic [7:0] req_dst_alpha_in = '0;
   logic [7:0] req_dst_red_in   = '0;
   logic [7:0] req_dst_green_in = '0;
   logic [7:0] req_dst_blue_in  = '0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_out_alpha;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;

   job_type           pixel_jobs[$];       // stimulus waiting for the driver
   blend_out_type     pending_blends[$];   // predicted pixels, oldest first
   pbu_pkg::mode_type shadow_mode    = pbu_pkg::MODE_NONE;
   int                gap_pct        = 0;  // chance the driver leaves a cycle empty
   int                stall_pct      = 0;  // chance the checker stalls the rsp_ channel
   int                in_flight      = 0;
   int                quiet_cycles   = 0;
   int                fail_count     = 0;
   int                mismatch_count = 0;

   pixel_blend_unit DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Blend one color channel with source alpha a as weight.
   function automatic logic [7:0] mix_channel(pbu_pkg::mode_type mode, logic [7:0] a,
                                              logic [7:0] s, logic [7:0] d);
      int unsigned ua, us, ud, part, r;
      ua = a;
      us = s;
      ud = d;
      case (mode)
         pbu_pkg::MODE_ALPHA: r = (us * ua + ud * (CH_MAX - ua)) >> 8;
         pbu_pkg::MODE_ADD: begin
            r = ud + ((us * ua) >> 8);
            if (r > CH_MAX) r = CH_MAX;
         end
         pbu_pkg::MODE_SUB: begin
            part = (us * ua) >> 8;
            r = (part > ud) ? 0 : ud - part;
         end
         pbu_pkg::MODE_MUL: r = ((ua * us * ud) >> 16) + (((CH_MAX - ua) * ud) >> 8);
         default:  r = ud;
      endcase
      return r[7:0];
   endfunction

   // Work out the destination pixel the block should return.
   function automatic blend_out_type blend_pixel(pbu_pkg::mode_type mode, pixel_pair_type p);
      blend_out_type o;
      if (mode == pbu_pkg::MODE_NONE) begin
         // Replace only when the source is not fully transparent.
         if (p.sa != 8'd0) o = '{p.sa, p.sr, p.sg, p.sb};
         else              o = '{p.da, p.dr, p.dg, p.db};
      end else begin
         o.alpha = p.da;
         o.red   = mix_channel(mode, p.sa, p.sr, p.dr);
         o.green = mix_channel(mode, p.sa, p.sg, p.dg);
         o.blue  = mix_channel(mode, p.sa, p.sb, p.db);
      end
      return o;
   endfunction

   task automatic queue_pixel(pixel_pair_type p);
      job_type j;
      j.kind = JOB_PIXEL;
      j.pix  = p;
      pixel_jobs.push_back(j);
   endtask

   task automatic queue_mode(pbu_pkg::mode_type m);
      job_type j;
      j.kind = JOB_MODE;
      j.mode = m;
      pixel_jobs.push_back(j);
   endtask

   task automatic queue_pace(int gap, int stall);
      job_type j;
      j.kind      = JOB_PACE;
      j.gap_pct   = gap;
      j.stall_pct = stall;
      pixel_jobs.push_back(j);
   endtask

   // Corners for every blended mode: saturation, floor, zero and mid weights.
   task automatic queue_corner_pixels();
      queue_pixel(64'hFFFFFFFF_FFFFFFFF);
      queue_pixel(64'h00000000_00000000);
      queue_pixel(64'hFFFFFFFF_00102030);
      queue_pixel(64'h80408020_C0FF0040);
   endtask

   task automatic queue_random_run(int count);
      pixel_pair_type p;
      int             pick;
      for (int i = 0; i < count; i++) begin
         if (i % MODE_EVERY == 0) begin
            // Mostly real modes, now and then a spare code.
            pick = $urandom_range(15);
            if (pick < 13) queue_mode(pbu_pkg::mode_type'(pick % 5));
            else           queue_mode(pbu_pkg::mode_type'(5 + $urandom_range(2)));
         end
         p = {$urandom, $urandom};
         // Pull source alpha to its ends often: they steer every mode.
         case ($urandom_range(7))
            0:       p.sa = 8'h00;
            1:       p.sa = 8'hFF;
            default: ;
         endcase
         queue_pixel(p);
      end
   endtask

   // Driver: hold a stalled transfer, otherwise take the next job from the queue.
   always @(posedge clock) begin : drive_proc
      logic req_taken, rsp_taken, next_valid, next_csr;
      if (reset) begin
         req_valid    <= 1'b0;
         csr_valid    <= 1'b0;
         in_flight    = 0;
         quiet_cycles = 0;
      end else begin
         req_taken  = req_valid && !req_stall;
         rsp_taken  = rsp_valid && !rsp_stall;
         // Track pixels inside the block from the handshakes alone.
         in_flight  = in_flight + int'(req_taken) - int'(rsp_taken);
         next_valid = req_valid && !req_taken;
         next_csr   = csr_valid && !csr_ready;
         if (in_flight == 0 && !next_valid && !next_csr) quiet_cycles++;
         else quiet_cycles = 0;

         if (!next_valid && !next_csr && pixel_jobs.size() != 0) begin
            case (pixel_jobs[0].kind)
               JOB_PACE: begin
                  gap_pct   <= pixel_jobs[0].gap_pct;
                  stall_pct <= pixel_jobs[0].stall_pct;
                  pixel_jobs.delete(0);
               end
               JOB_MODE: begin
                  // Write the mode only once the pipeline has drained.
                  if (quiet_cycles >= SETTLE_CYCLES) begin
                     next_csr = 1'b1;
                     csr_blend_mode <= pixel_jobs[0].mode;
                     pixel_jobs.delete(0);
                  end
               end
               JOB_PIXEL: begin
                  if ($urandom_range(99) >= gap_pct) begin
                     next_valid = 1'b1;
                     req_src_alpha    <= pixel_jobs[0].pix.sa;
                     req_src_red      <= pixel_jobs[0].pix.sr;
                     req_src_green    <= pixel_jobs[0].pix.sg;
                     req_src_blue     <= pixel_jobs[0].pix.sb;
                     req_dst_alpha_in <= pixel_jobs[0].pix.da;
                     req_dst_red_in   <= pixel_jobs[0].pix.dr;
                     req_dst_green_in <= pixel_jobs[0].pix.dg;
                     req_dst_blue_in  <= pixel_jobs[0].pix.db;
                     pixel_jobs.delete(0);
                  end
               end
               default: pixel_jobs.delete(0);
            endcase
         end
         req_valid <= next_valid;
         csr_valid <= next_csr;
      end
   end

   // Checker: compare each rsp_ transfer with the oldest prediction, then predict
   // the pixel taken on req_ at this edge.
   always @(posedge clock) begin : check_proc
      blend_out_type  want;
      pixel_pair_type took;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) shadow_mode = pbu_pkg::mode_type'(csr_blend_mode);

         if (rsp_valid && !rsp_stall) begin
            if (pending_blends.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result with nothing pending: a=%h r=%h g=%h b=%h", $realtime,
                           rsp_out_alpha, rsp_out_red, rsp_out_green, rsp_out_blue);
            end else begin
               want = pending_blends.pop_front();
               if (rsp_out_alpha !== want.alpha || rsp_out_red !== want.red ||
                   rsp_out_green !== want.green || rsp_out_blue !== want.blue) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: pixel mismatch: expected a=%h r=%h g=%h b=%h,",
                              $realtime, want.alpha, want.red, want.green, want.blue,
                              " got a=%h r=%h g=%h b=%h",
                              rsp_out_alpha, rsp_out_red, rsp_out_green, rsp_out_blue);
               end
            end
         end

         if (req_valid && !req_stall) begin
            took = {req_src_alpha, req_src_red, req_src_green, req_src_blue,
                    req_dst_alpha_in, req_dst_red_in, req_dst_green_in, req_dst_blue_in};
            pending_blends.push_back(blend_pixel(shadow_mode, took));
         end

         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      // Directed part: start under the reset mode, then visit every mode and the spare codes 5 and 7.
      queue_pace(21, 50);
      queue_pixel(64'h00123456_ABCDEF01);   // transparent source keeps destination
      queue_pixel(64'hFF9A7B5C_10203040);   // opaque source replaces it
      queue_pixel(64'h01FF00FF_EE112233);   // faintest visible source still replaces
      queue_mode(pbu_pkg::MODE_NONE);
      queue_pixel(64'h80C0D0E0_7F010203);
      queue_mode(pbu_pkg::MODE_ALPHA);
      queue_corner_pixels();
      queue_mode(pbu_pkg::MODE_ADD);
      queue_corner_pixels();
      queue_mode(pbu_pkg::MODE_SUB);
      queue_corner_pixels();
      queue_mode(pbu_pkg::MODE_MUL);
      queue_corner_pixels();
      queue_mode(MODE_SPARE_5);
      queue_pixel(64'hFFFFFFFF_5A6B7C8D);
      queue_mode(MODE_SPARE_7);
      queue_pixel(64'hFF00FF00_A5B6C7D8);

      // Random part in three pacing phases; the last one runs at full rate.
      queue_random_run(RANDOM_PER_PHASE);
      queue_pace(50, 21);
      queue_random_run(RANDOM_PER_PHASE);
      queue_pace(0, 0);
      queue_random_run(RANDOM_PER_PHASE);

      // Release reset once, synchronously.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last transfer and its result, then watch for strays.
      @(negedge clock);
      while (pixel_jobs.size() != 0 || req_valid || csr_valid || pending_blends.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_top failed");
      $finish;
   end

endmodule
